[rtl/core/mips_subset_instruction_executor_core_defines.svh]
// Assertion macros shared by the core RTL.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
// Check that an implication holds on every clock edge outside reset.
`define MSIE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an implication holds on every clock edge, reset included.
`define MSIE_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/msie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_pkg
// Types, opcodes and constants of the MIPS subset executor.
// ----------------------------------------------------------------------------
package msie_pkg;
	localparam int DATA_BYTES_DEF = 1024;
	localparam int REG_COUNT_DEF  = 32;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDI_NOTRAP = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_NORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LH    = 6'h21;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_LHU   = 6'h25;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SH    = 6'h29;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_HALT  = 6'h3F;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_NAND = 6'h28;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [0:0] FUNC_EXEC    = 1'b0;
	localparam logic [0:0] FUNC_PRELOAD = 1'b1;

	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	localparam logic [0:0] CFG_START_PC = 1'b0;
	localparam logic [0:0] CFG_START_SP = 1'b1;

	// load kinds
	typedef enum logic [2:0] {
		LD_NONE, LD_B, LD_BU, LD_H, LD_HU, LD_W
	} ld_kind_t;

	// register file write request
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] val;
	} rf_wr_t;

	// config writes into state
	typedef struct packed {
		logic        pc_en;
		logic        sp_en;
		logic [31:0] val;
	} cfg_wr_t;
endpackage

[rtl/core/mips_subset_instruction_executor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// MIPS subset executor with register file, byte data memory and halt flag.
// ----------------------------------------------------------------------------
// One item enters per clock while s_tready is high. An item is decoded and
// executed in stage one against the register file (with the pending load
// result forwarded); loads finish in stage two when the data memory returns
// its registered read. A store lands at its accepting edge, so a load right
// behind it reads the new bytes. Results leave through a two-entry output
// queue; input is refused while the queue and stage two hold two results and
// none leaves in that cycle, or while they hold three and one leaves.
// Register file: 32 flip-flop words with one write port for stage one and one
// for the stage-two load. Data memory: four byte-lane memories.
module mips_subset_instruction_executor_core #(
	parameter int DATA_BYTES = msie_pkg::DATA_BYTES_DEF,
	parameter int REG_COUNT  = msie_pkg::REG_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: instruction_word[31:0], preload_address[41:32], preload_word[73:42], pad
	input  logic [79:0]  s_tdata,
	// tuser: func
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: next_pc[31:0], halted[32], overflow[33], reg_written[34],
	// reg_index[39:35], reg_value[71:40]
	output logic [71:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import msie_pkg::*;
	`include "mips_subset_instruction_executor_core_defines.svh"

	localparam int AW = $clog2(DATA_BYTES);

	logic [31:0] start_pc_q, start_sp_q, pc_q;
	logic halt_q;
	cfg_wr_t cfg;

	assign pready = 1'b1;
	always_comb begin
		cfg.val = pwdata;
		cfg.pc_en = psel && penable && pwrite && paddr[2] == CFG_START_PC && paddr[1:0] == 2'd0;
		cfg.sp_en = psel && penable && pwrite && paddr[2] == CFG_START_SP && paddr[1:0] == 2'd0;
	end
	assign prdata = (paddr[2] == CFG_START_SP) ? start_sp_q : start_pc_q;

	// output queue, two entries
	logic [71:0] oq_q [2];
	logic [1:0] ocnt_q;
	logic rd_ptr_q;
	logic s2_ld_q;
	logic v_s2;
	logic [71:0] res_s2;
	ld_kind_t ld_s2;
	logic [4:0] ldst_s2;
	logic [31:0] mdata;
	logic [31:0] ldval;

	logic in_acc, out_acc;
	// room for stage two plus this one, counting a result that leaves now
	assign s_tready = ({1'b0, ocnt_q} + {2'b00, v_s2}) < (3'd2 + {2'b00, out_acc});
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign m_tvalid = ocnt_q != 2'd0;
	assign m_tdata = oq_q[rd_ptr_q];

	// stage one: decode and execute
	logic [31:0] iw;
	logic [5:0] op, fn;
	logic [4:0] rs, rt, rd, sh;
	logic [31:0] imm, simm, vs, vt, rvs, rvt, ea, pc4, npc, val;
	logic known, dowr, ovf, halt_set;
	logic [4:0] dst;
	ld_kind_t ldk;
	logic [3:0] st_en;
	logic [31:0] st_data;
	rf_wr_t rfw, rf_ld;

	assign iw = s_tdata[31:0];
	assign op = iw[31:26];
	assign rs = iw[25:21];
	assign rt = iw[20:16];
	assign rd = iw[15:11];
	assign sh = iw[10:6];
	assign fn = iw[5:0];
	assign imm = {16'd0, iw[15:0]};
	assign simm = {{16{iw[15]}}, iw[15:0]};

	msie_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
		.clk(clk), .arst_n(arst_n), .wr(rfw), .ld_wr(rf_ld), .sp_en(cfg.sp_en),
		.sp_val(cfg.val), .ra_idx(rs), .rb_idx(rt), .ra_val(rvs), .rb_val(rvt)
	);

	// forward the load completing in stage two
	assign vs = (s2_ld_q && ldst_s2 == rs && rs != 5'd0) ? ldval : rvs;
	assign vt = (s2_ld_q && ldst_s2 == rt && rt != 5'd0) ? ldval : rvt;
	assign ea = vs + simm;
	assign pc4 = pc_q + 32'd4;

	always_comb begin
		known = 1'b1; dowr = 1'b0; ovf = 1'b0; halt_set = 1'b0; ldk = LD_NONE;
		st_en = 4'b0000; st_data = vt; npc = pc4; val = '0; dst = rt;
		if (op == OP_SPECIAL) begin
			dst = rd; dowr = 1'b1;
			case (fn)
				FN_ADD: begin val = vs + vt; ovf = (vs[31] ~^ vt[31]) & (val[31] ^ vs[31]); end
				FN_SUB: begin val = vs - vt; ovf = (vs[31] ^ vt[31]) & (val[31] ^ vs[31]); end
				FN_AND: val = vs & vt;
				FN_OR: val = vs | vt;
				FN_XOR: val = vs ^ vt;
				FN_NOR: val = ~(vs | vt);
				FN_NAND: val = ~(vs & vt);
				FN_SLT: val = {31'd0, $signed(vs) < $signed(vt)};
				FN_SLL: val = vt << sh;
				FN_SRL: val = vt >> sh;
				FN_SRA: val = 32'($signed(vt) >>> sh);
				FN_JR: begin dowr = 1'b0; npc = vs; end
				default: begin dowr = 1'b0; known = 1'b0; end
			endcase
		end else begin
			dowr = 1'b1;
			case (op)
				OP_ADDI: begin
					val = vs + simm; ovf = (vs[31] ~^ simm[31]) & (val[31] ^ vs[31]);
				end
				OP_ADDI_NOTRAP: val = vs + simm;
				OP_LW: ldk = LD_W;
				OP_LH: ldk = LD_H;
				OP_LHU: ldk = LD_HU;
				OP_LB: ldk = LD_B;
				OP_LBU: ldk = LD_BU;
				OP_SW: begin dowr = 1'b0; st_en = 4'b1111; end
				OP_SH: begin dowr = 1'b0; st_en = 4'b1100; st_data = {vt[15:0], 16'd0}; end
				OP_SB: begin dowr = 1'b0; st_en = 4'b1000; st_data = {vt[7:0], 24'd0}; end
				OP_LUI: val = {iw[15:0], 16'd0};
				OP_ANDI: val = vs & imm;
				OP_ORI: val = vs | imm;
				OP_NORI: val = ~(vs | imm);
				OP_SLTI: val = {31'd0, $signed(vs) < $signed(simm)};
				OP_BEQ: begin dowr = 1'b0; if (vs == vt) npc = pc4 + (simm << 2); end
				OP_BNE: begin dowr = 1'b0; if (vs != vt) npc = pc4 + (simm << 2); end
				OP_J: begin dowr = 1'b0; npc = {pc4[31:28], iw[25:0], 2'b00}; end
				OP_JAL: begin dst = REG_RA; val = pc4; npc = {pc4[31:28], iw[25:0], 2'b00}; end
				OP_HALT: begin dowr = 1'b0; halt_set = 1'b1; end
				default: begin dowr = 1'b0; known = 1'b0; end
			endcase
		end
		if (!known) begin
			dowr = 1'b0; ovf = 1'b0; ldk = LD_NONE; st_en = 4'b0000;
		end
		if (dst == 5'd0) dowr = 1'b0;
		if (ldk != LD_NONE && dst == 5'd0) ldk = LD_NONE;
		if (ldk != LD_NONE) dowr = 1'b0;
	end

	logic exec_go, pre_go;
	assign pre_go = in_acc && s_tuser == FUNC_PRELOAD;
	assign exec_go = in_acc && s_tuser == FUNC_EXEC && !halt_q;

	// stage-one result and stage-two load use separate write ports
	always_comb begin
		rfw.en = exec_go && known && dowr;
		rfw.idx = dst;
		rfw.val = val;
		rf_ld.en = s2_ld_q;
		rf_ld.idx = ldst_s2;
		rf_ld.val = ldval;
	end

	// memory side
	logic [AW-1:0] m_raddr, m_waddr;
	logic [3:0] m_wen;
	logic [31:0] m_wdata;
	assign m_raddr = ea[AW-1:0];
	always_comb begin
		m_wen = 4'b0000; m_waddr = ea[AW-1:0]; m_wdata = st_data;
		if (pre_go) begin
			m_wen = 4'b1111;
			m_waddr = AW'({s_tdata[41:34], 2'b00});
			m_wdata = s_tdata[73:42];
		end else if (exec_go && known) begin
			m_wen = st_en;
		end
	end

	msie_dmem #(.DATA_BYTES(DATA_BYTES)) u_mem (
		.clk(clk), .rd_addr(m_raddr), .rd_data(mdata),
		.wr_en(m_wen), .wr_addr(m_waddr), .wr_data(m_wdata)
	);

	// load formatting in stage two
	always_comb begin
		case (ld_s2)
			LD_W: ldval = mdata;
			LD_H: ldval = {{16{mdata[31]}}, mdata[31:16]};
			LD_HU: ldval = {16'd0, mdata[31:16]};
			LD_B: ldval = {{24{mdata[31]}}, mdata[31:24]};
			LD_BU: ldval = {24'd0, mdata[31:24]};
			default: ldval = '0;
		endcase
	end

	logic [71:0] res_now;
	logic [31:0] pc_next;
	logic halt_next;
	always_comb begin
		pc_next = pc_q; halt_next = halt_q;
		if (exec_go && known) begin pc_next = npc; halt_next = halt_q | halt_set; end
		res_now = {rfw.en ? val : 32'd0, rfw.en ? dst : 5'd0, rfw.en,
			exec_go & ovf, halt_next, pc_next};
	end

	logic [71:0] res_fin;
	always_comb begin
		res_fin = res_s2;
		if (s2_ld_q) begin
			res_fin[71:40] = ldval; res_fin[39:35] = ldst_s2; res_fin[34] = 1'b1;
		end
	end

	// stage register and queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; s2_ld_q <= 1'b0; ocnt_q <= '0; rd_ptr_q <= 1'b0;
			pc_q <= '0; halt_q <= 1'b0; start_pc_q <= '0; start_sp_q <= '0;
		end else begin
			pc_q <= cfg.pc_en ? cfg.val : pc_next;
			halt_q <= halt_next;
			if (cfg.pc_en) start_pc_q <= cfg.val;
			if (cfg.sp_en) start_sp_q <= cfg.val;
			v_s2 <= in_acc;
			s2_ld_q <= exec_go && known && ldk != LD_NONE;
			ocnt_q <= ocnt_q + {1'b0, v_s2} - {1'b0, out_acc};
			if (out_acc) rd_ptr_q <= ~rd_ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_now;
		ld_s2 <= ldk;
		ldst_s2 <= dst;
		// tail slot is head plus count
		if (v_s2) oq_q[rd_ptr_q ^ ocnt_q[0]] <= res_fin;
	end

	`MSIE_ASSERT(a_occ, clk, arst_n, ocnt_q <= 2'd2, "output queue overrun")
	`MSIE_ASSERT(a_halt, clk, arst_n, halt_q |=> halt_q || $past(cfg.pc_en), "halt dropped")
	`MSIE_ASSERT(a_ready, clk, arst_n, (ocnt_q == 2'd2 && !m_tready) |-> !s_tready, "ready while full")
	`MSIE_ASSERT(a_pend, clk, arst_n, s2_ld_q |-> v_s2, "load without item")
endmodule

[rtl/core/msie_regfile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_regfile
// 32 x 32 register file, two combinational read ports and two write ports.
// ----------------------------------------------------------------------------
module msie_regfile #(
	parameter int REG_COUNT = msie_pkg::REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msie_pkg::rf_wr_t    wr,
	input  msie_pkg::rf_wr_t    ld_wr,
	input  logic                sp_en,
	input  logic [31:0]         sp_val,
	input  logic [4:0]          ra_idx,
	input  logic [4:0]          rb_idx,
	output logic [31:0]         ra_val,
	output logic [31:0]         rb_val
);
	import msie_pkg::*;

	logic [31:0] regs_q [REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= '0;
		end else if (sp_en) begin
			regs_q[REG_SP] <= sp_val;
		end else begin
			if (wr.en && wr.idx != 5'd0) regs_q[wr.idx] <= wr.val;
			// the younger stage-one write wins on the same register
			if (ld_wr.en && ld_wr.idx != 5'd0 && !(wr.en && wr.idx == ld_wr.idx))
				regs_q[ld_wr.idx] <= ld_wr.val;
		end
	end

	assign ra_val = (ra_idx == 5'd0) ? 32'd0 : regs_q[ra_idx];
	assign rb_val = (rb_idx == 5'd0) ? 32'd0 : regs_q[rb_idx];
endmodule

[rtl/core/msie_dmem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_dmem
// Byte data memory as four byte lanes; any four consecutive bytes in one cycle.
// ----------------------------------------------------------------------------
module msie_dmem #(
	parameter int DATA_BYTES = msie_pkg::DATA_BYTES_DEF,
	localparam int AW = $clog2(DATA_BYTES),
	localparam int LW = AW - 2
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic [3:0]    wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);
	import msie_pkg::*;

	logic [7:0] lane0 [DATA_BYTES/4];
	logic [7:0] lane1 [DATA_BYTES/4];
	logic [7:0] lane2 [DATA_BYTES/4];
	logic [7:0] lane3 [DATA_BYTES/4];
	logic [LW-1:0] rrow [4];
	logic [LW-1:0] wrow [4];
	logic [7:0] wbyte [4];
	logic [3:0] wlane;
	logic [7:0] q [4];
	logic [1:0] rsh_q;
	logic [7:0] b [4];

	// byte k of the access sits at address+k; its lane is (address+k)%4
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			logic [1:0] k;
			logic [AW-1:0] a;
			k = 2'(l) - rd_addr[1:0];
			a = rd_addr + AW'(k);
			rrow[l] = a[AW-1:2];
			k = 2'(l) - wr_addr[1:0];
			a = wr_addr + AW'(k);
			wrow[l] = a[AW-1:2];
			wbyte[l] = wr_data[8*(3-k) +: 8];
			wlane[l] = wr_en[3-k];
		end
	end

	always_ff @(posedge clk) begin
		if (wlane[0]) lane0[wrow[0]] <= wbyte[0];
		if (wlane[1]) lane1[wrow[1]] <= wbyte[1];
		if (wlane[2]) lane2[wrow[2]] <= wbyte[2];
		if (wlane[3]) lane3[wrow[3]] <= wbyte[3];
		q[0] <= lane0[rrow[0]];
		q[1] <= lane1[rrow[1]];
		q[2] <= lane2[rrow[2]];
		q[3] <= lane3[rrow[3]];
		rsh_q <= rd_addr[1:0];
	end

	always_comb begin
		for (int k = 0; k < 4; k++) b[k] = q[2'(k) + rsh_q];
		rd_data = {b[0], b[1], b[2], b[3]};
	end
endmodule
